// File: sv/wad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wad_pkg
// Shared types and constants of the window average deviation detector.
// ----------------------------------------------------------------------------
package wad_pkg;

  localparam int SAMPLE_W = 10;
  localparam int DEFAULT_CAPACITY = 8;
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd100;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

endpackage
`default_nettype wire

// File: sv/wad_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wad_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wad_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/wad_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wad_front
// Accepts requests, decodes the function code and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module wad_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic [wad_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                               q_valid,
  output wad_pkg::item_t                     q_item,
  input  wire logic                          q_pop
);
  import wad_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  item_t      decoded;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    decoded.op     = in_func ? OP_CLEAR : OP_SAMPLE;
    decoded.sample = in_func ? '0 : in_sample;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= decoded;
    end
  end

endmodule
`default_nettype wire

// File: sv/wad_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wad_back
// Window update, running sum, iterative mean division, deviation test and
// the result register.
// ----------------------------------------------------------------------------
module wad_back #(
  parameter int CAPACITY = wad_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire wad_pkg::item_t                q_item,
  output logic                               q_pop,
  input  wire logic [wad_pkg::SAMPLE_W-1:0]  threshold,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [wad_pkg::SAMPLE_W-1:0]  out_reading,
  output logic      [wad_pkg::SAMPLE_W-1:0]  out_mean,
  output logic                               out_window_full,
  output logic                               out_deviation,
  output logic                               out_detected
);
  import wad_pkg::*;

  localparam int POS_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(CAPACITY);
  localparam int DIV_W  = (SUM_W > CNT_W + SAMPLE_W - 1) ? SUM_W : CNT_W + SAMPLE_W - 1;
  localparam int STEP_W = $clog2(SAMPLE_W);
  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SAMPLE_W - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                det_r, det_nxt;
  logic                was_full_r, was_full_nxt;
  logic [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]    dvs_r, dvs_nxt;
  logic [SAMPLE_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                ov_r, ov_nxt;
  logic [SAMPLE_W-1:0] o_reading_r, o_mean_r;
  logic                o_full_r, o_dev_r, o_det_r;

  logic [POS_W-1:0]    pos_adv;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [SAMPLE_W-1:0] old_smp;
  logic [SUM_W-1:0]    sum_new;
  logic                take;
  logic                full;
  logic [SAMPLE_W-1:0] gap;
  logic                dev;
  logic                load;
  logic                ram_we;

  assign pos_adv = (pos_r == POS_LAST) ? '0 : pos_r + POS_W'(1);
  assign old_smp = was_full_r ? ram_rdata : '0;
  assign sum_new = sum_r - SUM_W'(old_smp) + SUM_W'(smp_r);
  assign take    = (rem_r >= dvs_r);
  assign full    = (cnt_r == CNT_FULL);
  assign gap     = (quo_r > smp_r) ? (quo_r - smp_r) : (smp_r - quo_r);
  assign dev     = full && (gap > threshold);
  assign load    = (state_r == S_FIN) && (!ov_r || out_ready);
  assign q_pop   = (state_r == S_IDLE) && q_valid;
  assign ram_we  = (state_r == S_RD);

  wad_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(CAPACITY)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pos_r),
    .wdata(smp_r),
    .raddr(pos_adv),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    det_nxt      = det_r;
    was_full_nxt = was_full_r;
    smp_nxt      = smp_r;
    rem_nxt      = rem_r;
    dvs_nxt      = dvs_r;
    quo_nxt      = quo_r;
    step_nxt     = step_r;
    ov_nxt       = ov_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.op == OP_CLEAR) begin
            pos_nxt   = '0;
            cnt_nxt   = '0;
            sum_nxt   = '0;
            det_nxt   = 1'b0;
            smp_nxt   = '0;
            quo_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            pos_nxt      = pos_adv;
            was_full_nxt = full;
            if (!full) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            smp_nxt   = q_item.sample;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        sum_nxt   = sum_new;
        rem_nxt   = DIV_W'(sum_new);
        dvs_nxt   = DIV_W'(cnt_r) << (SAMPLE_W - 1);
        quo_nxt   = '0;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (take) begin
          rem_nxt = rem_r - dvs_r;
        end
        quo_nxt  = {quo_r[SAMPLE_W-2:0], take};
        dvs_nxt  = dvs_r >> 1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (load) begin
          det_nxt   = det_r || dev;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      det_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      det_r   <= det_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    was_full_r <= was_full_nxt;
    smp_r      <= smp_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    if (load) begin
      o_reading_r <= smp_r;
      o_mean_r    <= quo_r;
      o_full_r    <= full;
      o_dev_r     <= dev;
      o_det_r     <= det_r || dev;
    end
  end

  assign out_valid       = ov_r;
  assign out_reading     = o_reading_r;
  assign out_mean        = o_mean_r;
  assign out_window_full = o_full_r;
  assign out_deviation   = o_dev_r;
  assign out_detected    = o_det_r;

endmodule
`default_nettype wire

// File: sv/window_average_deviation_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_average_deviation_detector
// Moving window mean of sensor samples with a sticky deviation flag.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_func, in_sample
//   out_     output     out_valid / out_ready  reading, mean, full, deviation,
//                                              detected
//   cfg_     input      cfg_we                 cfg_wdata (threshold)
//
// A sample request passes through the back end in order: pop the queue and
// read the oldest entry, update the window and sum, run the restoring
// division by the fill count, and load the result register. A clear request
// pops the queue and then loads the result register. Reset is synchronous
// and needs no clearing pass. A two-entry queue accepts requests while the
// back end works or a result waits for out_ready, until both entries fill.
// ----------------------------------------------------------------------------
module window_average_deviation_detector #(
  parameter int CAPACITY = wad_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic [wad_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [wad_pkg::SAMPLE_W-1:0]  out_reading,
  output logic      [wad_pkg::SAMPLE_W-1:0]  out_mean,
  output logic                               out_window_full,
  output logic                               out_deviation,
  output logic                               out_detected,
  input  wire logic                          cfg_we,
  input  wire logic [wad_pkg::SAMPLE_W-1:0]  cfg_wdata
);
  import wad_pkg::*;

  logic [SAMPLE_W-1:0] threshold_r;
  logic                q_valid;
  item_t               q_item;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold_r <= cfg_wdata;
    end
  end

  wad_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .in_sample(in_sample),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  wad_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .threshold      (threshold_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reading    (out_reading),
    .out_mean       (out_mean),
    .out_window_full(out_window_full),
    .out_deviation  (out_deviation),
    .out_detected   (out_detected)
  );

endmodule
`default_nettype wire
